@@ hw/rtl/rc4_pkg.sv @@
// Shared types and constants for the RC4 stream cipher block.
// No dependencies; used by rc4_ctrl and rc4_stream_cipher.
package rc4_pkg;

   localparam int ByteW     = 8;
   localparam int PermDepth = 256;
   localparam int KeyBits   = 128;
   localparam int KeyIdxW   = 4;
   localparam int KeyLenW   = 5;
   localparam int CsrIdxW   = 2;
   localparam int CsrDataW  = 64;

   localparam logic [KeyLenW-1:0] MaxKeyBytes = 5'd16;
   localparam logic [KeyLenW-1:0] MinKeyBytes = 5'd1;
   localparam logic [ByteW-1:0]   LastEntry   = 8'd255;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CsrKeyLength   = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrKeyBytesLow  = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrKeyBytesHigh = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KS_INIT,
      ST_KS_RD,
      ST_KS_J,
      ST_KS_WN,
      ST_KS_WJ,
      ST_RD_I,
      ST_J,
      ST_SW,
      ST_WJ,
      ST_HOLD
   } ctrl_state_type;

   // result offered by the sequencer to the output register
   typedef struct packed {
      logic             valid;
      logic [ByteW-1:0] data;
   } result_type;

endpackage

@@ hw/rtl/rc4_ram.sv @@
// Generic synchronous RAM: one write port, one read port, registered read.
// No dependencies.
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/rc4_ctrl.sv @@
// Sequencer and datapath for RC4: key schedule and keystream generation
// over the permutation RAM. Depends on rc4_pkg and drives an rc4_ram.
module rc4_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rc4_pkg::ByteW-1:0]         req_data_byte,
   input  logic                              req_start_message,
   input  logic [rc4_pkg::KeyBits-1:0]       key_bits,
   input  logic [rc4_pkg::KeyLenW-1:0]       key_len,
   input  logic                              out_free,
   output rc4_pkg::result_type               result,
   output logic                              ram_wr_en,
   output logic [rc4_pkg::ByteW-1:0]         ram_wr_addr,
   output logic [rc4_pkg::ByteW-1:0]         ram_wr_data,
   output logic [rc4_pkg::ByteW-1:0]         ram_rd_addr,
   input  logic [rc4_pkg::ByteW-1:0]         ram_rd_data
);

   rc4_pkg::ctrl_state_type state_ff, state_in;

   logic [rc4_pkg::ByteW-1:0]   n_ff, n_in;
   logic [rc4_pkg::KeyIdxW-1:0] k_ff, k_in;
   logic [rc4_pkg::ByteW-1:0]   i_ff, i_in;
   logic [rc4_pkg::ByteW-1:0]   j_ff, j_in;
   logic [rc4_pkg::ByteW-1:0]   si_ff, si_in;
   logic [rc4_pkg::ByteW-1:0]   sj_ff, sj_in;
   logic [rc4_pkg::ByteW-1:0]   t_ff, t_in;
   logic [rc4_pkg::ByteW-1:0]   data_ff, data_in;
   logic [rc4_pkg::ByteW-1:0]   hold_ff, hold_in;

   logic [rc4_pkg::ByteW-1:0] key_byte;
   logic                      key_last;
   logic [rc4_pkg::ByteW-1:0] st_fwd;
   logic                      n_last;

   assign key_byte = key_bits[{k_ff, 3'b000} +: rc4_pkg::ByteW];
   assign key_last = ({1'b0, k_ff} + rc4_pkg::KeyLenW'(1)) == key_len;
   assign n_last   = (n_ff == rc4_pkg::LastEntry);

   // S[t] read was issued while S[i] was being written and S[j] still pending
   assign st_fwd = (t_ff == j_ff) ? si_ff :
                   (t_ff == i_ff) ? sj_ff : ram_rd_data;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rc4_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = req_start_message ? rc4_pkg::ST_KS_INIT : rc4_pkg::ST_J;
            end
         end
         rc4_pkg::ST_KS_INIT: begin
            if (n_last) begin
               state_in = rc4_pkg::ST_KS_RD;
            end
         end
         rc4_pkg::ST_KS_RD: state_in = rc4_pkg::ST_KS_J;
         rc4_pkg::ST_KS_J:  state_in = rc4_pkg::ST_KS_WN;
         rc4_pkg::ST_KS_WN: state_in = rc4_pkg::ST_KS_WJ;
         rc4_pkg::ST_KS_WJ: state_in = n_last ? rc4_pkg::ST_RD_I : rc4_pkg::ST_KS_RD;
         rc4_pkg::ST_RD_I:  state_in = rc4_pkg::ST_J;
         rc4_pkg::ST_J:     state_in = rc4_pkg::ST_SW;
         rc4_pkg::ST_SW:    state_in = rc4_pkg::ST_WJ;
         rc4_pkg::ST_WJ:    state_in = out_free ? rc4_pkg::ST_IDLE : rc4_pkg::ST_HOLD;
         rc4_pkg::ST_HOLD:  state_in = out_free ? rc4_pkg::ST_IDLE : rc4_pkg::ST_HOLD;
         default:           state_in = rc4_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      result      = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      ram_rd_addr = '0;
      n_in        = n_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      si_in       = si_ff;
      sj_in       = sj_ff;
      t_in        = t_ff;
      data_in     = data_ff;
      hold_in     = hold_ff;
      case (state_ff)
         rc4_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               data_in = req_data_byte;
               n_in    = '0;
               if (!req_start_message) begin
                  ram_rd_addr = i_ff + rc4_pkg::ByteW'(1);
                  i_in        = i_ff + rc4_pkg::ByteW'(1);
               end
            end
         end
         rc4_pkg::ST_KS_INIT: begin
            // load identity permutation
            ram_wr_en   = 1'b1;
            ram_wr_addr = n_ff;
            ram_wr_data = n_ff;
            n_in        = n_ff + rc4_pkg::ByteW'(1);
            if (n_last) begin
               j_in = '0;
               k_in = '0;
            end
         end
         rc4_pkg::ST_KS_RD: begin
            ram_rd_addr = n_ff;
         end
         rc4_pkg::ST_KS_J: begin
            si_in       = ram_rd_data;
            j_in        = j_ff + ram_rd_data + key_byte;
            ram_rd_addr = j_in;
            k_in        = key_last ? '0 : k_ff + rc4_pkg::KeyIdxW'(1);
         end
         rc4_pkg::ST_KS_WN: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = n_ff;
            ram_wr_data = ram_rd_data;
         end
         rc4_pkg::ST_KS_WJ: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = j_ff;
            ram_wr_data = si_ff;
            n_in        = n_ff + rc4_pkg::ByteW'(1);
            if (n_last) begin
               i_in = '0;
               j_in = '0;
            end
         end
         rc4_pkg::ST_RD_I: begin
            ram_rd_addr = i_ff + rc4_pkg::ByteW'(1);
            i_in        = i_ff + rc4_pkg::ByteW'(1);
         end
         rc4_pkg::ST_J: begin
            si_in       = ram_rd_data;
            j_in        = j_ff + ram_rd_data;
            ram_rd_addr = j_in;
         end
         rc4_pkg::ST_SW: begin
            sj_in       = ram_rd_data;
            ram_wr_en   = 1'b1;
            ram_wr_addr = i_ff;
            ram_wr_data = ram_rd_data;
            t_in        = si_ff + ram_rd_data;
            ram_rd_addr = t_in;
         end
         rc4_pkg::ST_WJ: begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = j_ff;
            ram_wr_data  = si_ff;
            result.valid = 1'b1;
            result.data  = st_fwd ^ data_ff;
            hold_in      = st_fwd ^ data_ff;
         end
         rc4_pkg::ST_HOLD: begin
            result.valid = 1'b1;
            result.data  = hold_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rc4_pkg::ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
      n_ff    <= n_in;
      k_ff    <= k_in;
      si_ff   <= si_in;
      sj_ff   <= sj_in;
      t_ff    <= t_in;
      data_ff <= data_in;
      hold_ff <= hold_in;
   end

endmodule

@@ hw/rtl/rc4_stream_cipher.sv @@
// Top level of the RC4 stream cipher: configuration registers, output
// register and the sequencer over one permutation RAM. Depends on rc4_pkg, rc4_ctrl and rc4_ram.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/ready     req_data_byte, req_start_message
//   rsp      out        rsp_valid/ready     rsp_result_byte
//   csr      in         csr_we              csr_index, csr_wdata
//
// A byte without start steps through, in order: read S[i] at the transfer,
// read S[j], write S[i] with read S[t], write S[j] with the result offered;
// the next byte is not taken until the sequencer is back in idle.
// A start byte first runs the key schedule: it fills the RAM with the identity
// permutation, then swaps each entry n (read S[n], read S[j], write both).
// Reset is synchronous; the permutation RAM is not cleared.
// A waiting result sits in the output register while the next byte transfers in.
module rc4_stream_cipher (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rc4_pkg::ByteW-1:0]          req_data_byte,
   input  logic                               req_start_message,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rc4_pkg::ByteW-1:0]          rsp_result_byte,
   input  logic                               csr_we,
   input  logic [rc4_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [rc4_pkg::CsrDataW-1:0]       csr_wdata
);

   logic [rc4_pkg::KeyLenW-1:0]  key_length_ff;
   logic [rc4_pkg::CsrDataW-1:0] key_low_ff;
   logic [rc4_pkg::CsrDataW-1:0] key_high_ff;
   logic [rc4_pkg::KeyLenW-1:0]  key_len;

   logic                      rsp_valid_ff;
   logic [rc4_pkg::ByteW-1:0] rsp_byte_ff;
   logic                      out_free;

   rc4_pkg::result_type ctrl_res;

   logic                      ram_wr_en;
   logic [rc4_pkg::ByteW-1:0] ram_wr_addr;
   logic [rc4_pkg::ByteW-1:0] ram_wr_data;
   logic [rc4_pkg::ByteW-1:0] ram_rd_addr;
   logic [rc4_pkg::ByteW-1:0] ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= rc4_pkg::MinKeyBytes;
         key_low_ff    <= '0;
         key_high_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rc4_pkg::CsrKeyLength:    key_length_ff <= csr_wdata[rc4_pkg::KeyLenW-1:0];
            rc4_pkg::CsrKeyBytesLow:  key_low_ff    <= csr_wdata;
            rc4_pkg::CsrKeyBytesHigh: key_high_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // clamp key length to 1..MaxKeyBytes
   assign key_len = (key_length_ff < rc4_pkg::MinKeyBytes) ? rc4_pkg::MinKeyBytes :
                    (key_length_ff > rc4_pkg::MaxKeyBytes) ? rc4_pkg::MaxKeyBytes :
                    key_length_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= ctrl_res.valid;
      end
      if (out_free && ctrl_res.valid) begin
         rsp_byte_ff <= ctrl_res.data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_byte = rsp_byte_ff;

   rc4_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_start_message (req_start_message),
      .key_bits          ({key_high_ff, key_low_ff}),
      .key_len           (key_len),
      .out_free          (out_free),
      .result            (ctrl_res),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data)
   );

   rc4_ram #(
      .WIDTH (rc4_pkg::ByteW),
      .DEPTH (rc4_pkg::PermDepth)
   ) u_perm_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // the sequencer never offers a result while it is ready for a new byte
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !ctrl_res.valid)
      else $error("result offered while idle");

   // one byte at a time: no transfer right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while busy");

   // output register only fills from an offered result
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl_res.valid))
      else $error("result appeared without sequencer output");

endmodule
